// File: sv/dre_pkg.sv
// Shared constants for the delta run encoder.
`timescale 1ns / 1ps

package dre_pkg;

    localparam int MAX_REGION_DEF = 65536;

    localparam int FIELD_W   = 16;
    localparam int CMP_W     = 17;
    localparam int PIECE_CNT_W = 5;

    localparam logic [15:0] PIECE_MIN   = 16'd4096;
    localparam logic [15:0] PIECE_MAX   = 16'h8000;
    localparam logic [15:0] COUNT_SAT   = 16'hFFFF;
    localparam logic [4:0]  MAX_PIECES  = 5'd16;

    localparam logic [3:0]  MERGE_GAP_RST = 4'd4;
    localparam logic [15:0] MAX_RUN_RST   = 16'h8000;

    localparam int          ADDR_W        = 3;
    localparam logic        REG_MERGE_GAP = 1'b0;
    localparam logic        REG_MAX_RUN   = 1'b1;

    localparam logic        KIND_RUN   = 1'b0;
    localparam logic        KIND_COUNT = 1'b1;

endpackage

// File: sv/delta_run_encoder_unit.sv
// Delta run encoder: sequencer around one shared subtractor emitting run pieces and counts.
// Steps: each byte passes S_IDLE, S_GAP, S_MARK (plus S_FIN on a region's final byte);
// each run piece S_PIECE and S_SEND, each closed run one more S_PIECE, the count record
// S_COUNT and S_SEND; an output stall holds S_SEND. A byte is taken only in S_IDLE, so
// no byte enters before the last is done; one subtractor serves gap check and piece length.
// Reset (synchronous, active low): position, run state and piece count clear to zero,
// merge_gap to 4, max_run_length to 32768; no clearing pass.
`timescale 1ns / 1ps

module delta_run_encoder_unit #(
    parameter int MAX_REGION = dre_pkg::MAX_REGION_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // APB configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [dre_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // input stream
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [15:0]               i_s_tdata,  // current_byte[7:0], reference_byte[15:8]
    input  logic                      i_s_tlast,  // end_of_region
    // output stream
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [47:0]               o_m_tdata,  // run_offset[15:0], run_length[31:16],
                                                  // run_count[47:32]
    output logic                      o_m_tuser,  // kind
    output logic                      o_m_tlast   // last
);

    localparam int PW = $clog2(MAX_REGION);
    localparam int EW = PW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAP,
        S_PIECE,
        S_SEND,
        S_MARK,
        S_FIN,
        S_COUNT
    } t_state;

    t_state r_state;

    logic [3:0]  r_merge_gap;
    logic [15:0] r_max_run;

    logic [PW-1:0] r_pos;
    logic          r_in_run;
    logic [PW-1:0] r_run_start;
    logic [PW-1:0] r_last_diff;
    logic [15:0]   r_pieces;

    logic          r_diff;
    logic          r_final;
    logic          r_second;
    logic [EW-1:0] r_start;
    logic [EW-1:0] r_end;
    logic [dre_pkg::PIECE_CNT_W-1:0] r_k;

    logic          r_m_valid;
    logic          r_m_kind;
    logic          r_m_last;
    logic [15:0]   r_m_off;
    logic [15:0]   r_m_len;
    logic [15:0]   r_m_cnt;

    logic                 s_accept;
    logic                 m_accept;
    logic                 cfg_wr;
    logic [EW-1:0]        sub_a;
    logic [EW-1:0]        sub_b;
    logic [EW-1:0]        sub_res;
    logic                 gap_exceeded;
    logic [15:0]          limit;
    logic                 fits;
    logic [15:0]          piece_len;
    logic                 more;

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite;
    assign prdata     = (paddr[2] == dre_pkg::REG_MAX_RUN) ? 32'(r_max_run)
                                                           : 32'(r_merge_gap);

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_valid;
    assign m_accept   = r_m_valid && i_m_tready;
    assign o_m_tdata  = {r_m_cnt, r_m_len, r_m_off};
    assign o_m_tuser  = r_m_kind;
    assign o_m_tlast  = r_m_last;

    // shared subtractor: gap distance or remaining run length
    always_comb begin
        if (r_state == S_GAP) begin
            sub_a = {1'b0, r_pos};
            sub_b = {1'b0, r_last_diff};
        end else begin
            sub_a = r_end;
            sub_b = r_start;
        end
        sub_res = sub_a - sub_b;
    end

    always_comb begin
        if (r_max_run < dre_pkg::PIECE_MIN) begin
            limit = dre_pkg::PIECE_MIN;
        end else if (r_max_run > dre_pkg::PIECE_MAX) begin
            limit = dre_pkg::PIECE_MAX;
        end else begin
            limit = r_max_run;
        end
    end

    assign gap_exceeded = sub_res > EW'(r_merge_gap);
    assign fits         = dre_pkg::CMP_W'(sub_res) <= dre_pkg::CMP_W'(limit);
    assign piece_len    = fits ? 16'(sub_res) : limit;
    assign more         = (r_start < r_end) && (r_k < dre_pkg::MAX_PIECES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_merge_gap <= dre_pkg::MERGE_GAP_RST;
            r_max_run   <= dre_pkg::MAX_RUN_RST;
            r_pos       <= '0;
            r_in_run    <= 1'b0;
            r_run_start <= '0;
            r_last_diff <= '0;
            r_pieces    <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == dre_pkg::REG_MAX_RUN) begin
                    r_max_run <= pwdata[15:0];
                end else begin
                    r_merge_gap <= pwdata[3:0];
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_diff  <= i_s_tdata[7:0] != i_s_tdata[15:8];
                        r_final <= i_s_tlast || (r_pos == PW'(MAX_REGION - 1));
                        r_k     <= '0;
                        r_state <= S_GAP;
                    end
                end
                S_GAP: begin
                    if (r_in_run && gap_exceeded) begin
                        r_start  <= {1'b0, r_run_start};
                        r_end    <= {1'b0, r_last_diff} + EW'(1);
                        r_second <= 1'b0;
                        r_state  <= S_PIECE;
                    end else begin
                        r_state <= S_MARK;
                    end
                end
                S_PIECE: begin
                    if (more) begin
                        r_m_valid <= 1'b1;
                        r_m_kind  <= dre_pkg::KIND_RUN;
                        r_m_off   <= 16'(r_start[PW-1:0]);
                        r_m_len   <= piece_len;
                        r_m_cnt   <= '0;
                        r_m_last  <= !r_final &&
                                     (fits || (r_k == dre_pkg::MAX_PIECES - 5'd1));
                        r_state   <= S_SEND;
                    end else begin
                        r_in_run <= 1'b0;
                        r_state  <= r_second ? S_COUNT : S_MARK;
                    end
                end
                S_SEND: begin
                    if (m_accept) begin
                        r_m_valid <= 1'b0;
                        if (r_m_kind == dre_pkg::KIND_COUNT) begin
                            r_pos       <= '0;
                            r_pieces    <= '0;
                            r_in_run    <= 1'b0;
                            r_run_start <= '0;
                            r_last_diff <= '0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_start <= r_start + EW'(r_m_len);
                            r_k     <= r_k + 5'd1;
                            if (r_pieces != dre_pkg::COUNT_SAT) begin
                                r_pieces <= r_pieces + 16'd1;
                            end
                            r_state <= S_PIECE;
                        end
                    end
                end
                S_MARK: begin
                    if (r_diff) begin
                        if (!r_in_run) begin
                            r_in_run    <= 1'b1;
                            r_run_start <= r_pos;
                        end
                        r_last_diff <= r_pos;
                    end
                    if (r_final) begin
                        r_state <= S_FIN;
                    end else begin
                        r_pos   <= r_pos + PW'(1);
                        r_state <= S_IDLE;
                    end
                end
                S_FIN: begin
                    if (r_in_run) begin
                        r_start  <= {1'b0, r_run_start};
                        r_end    <= {1'b0, r_last_diff} + EW'(1);
                        r_second <= 1'b1;
                        r_state  <= S_PIECE;
                    end else begin
                        r_state <= S_COUNT;
                    end
                end
                S_COUNT: begin
                    r_m_valid <= 1'b1;
                    r_m_kind  <= dre_pkg::KIND_COUNT;
                    r_m_off   <= '0;
                    r_m_len   <= '0;
                    r_m_cnt   <= r_pieces;
                    r_m_last  <= 1'b1;
                    r_state   <= S_SEND;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
